### hw/rtl/dqdd_pkg.sv
// Shared types, constants and helpers for the dual quadrature distance drive.
`timescale 1ns / 1ps
`default_nettype none

package dqdd_pkg;

  localparam int unsigned SPEED_W = 16;
  localparam int unsigned MAG_W   = 15;
  localparam int unsigned DIST_W  = 16;
  localparam int unsigned HIST_W  = 4;

  localparam logic [DIST_W-1:0]  NOT_SET_CODE = 16'hFFFF;
  localparam logic [HIST_W-1:0]  HIST_MASK    = 4'b1111;
  localparam logic [1:0]         PAIR_MASK    = 2'b11;
  localparam logic [SPEED_W-1:0] SPEED_MOST_NEG = 16'h8000;
  localparam logic [SPEED_W-1:0] SPEED_SAT_NEG  = 16'h8001;

  // Quadrature transition table, indexed by {previous pair, new pair}.
  localparam logic signed [1:0] STEP_TABLE [16] = '{
    2'sd0, -2'sd1, 2'sd1, 2'sd0, 2'sd1, 2'sd0, 2'sd0, -2'sd1,
    -2'sd1, 2'sd0, 2'sd0, 2'sd1, 2'sd0, 2'sd1, -2'sd1, 2'sd0
  };

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_DRIVE  = 1'b1;

  typedef struct packed {
    logic              command;
    logic              left_chan_a;
    logic              left_chan_b;
    logic              right_chan_a;
    logic              right_chan_b;
    logic [SPEED_W-1:0] left_speed_cmd;
    logic [SPEED_W-1:0] right_speed_cmd;
    logic [DIST_W-1:0]  left_distance_cmd;
    logic [DIST_W-1:0]  right_distance_cmd;
  } item_t;

  typedef struct packed {
    logic [HIST_W-1:0]  left_hist;
    logic [HIST_W-1:0]  right_hist;
    logic [DIST_W-1:0]  left_dist;
    logic [DIST_W-1:0]  right_dist;
    logic [SPEED_W-1:0] left_speed;
    logic [SPEED_W-1:0] right_speed;
    logic               enabled;
  } drive_state_t;

  typedef struct packed {
    logic               drive_enable;
    logic               left_dir;
    logic               right_dir;
    logic [DIST_W-1:0]  left_compare;
    logic [DIST_W-1:0]  right_compare;
    logic [DIST_W-1:0]  left_remaining;
    logic [DIST_W-1:0]  right_remaining;
    logic               stopped_now;
  } result_t;

  // Magnitude of a saturated signed speed (never the most negative code).
  function automatic logic [MAG_W-1:0] speed_mag(input logic [SPEED_W-1:0] s);
    logic [SPEED_W-1:0] neg;
    neg = (~s) + 16'd1;
    return s[SPEED_W-1] ? neg[MAG_W-1:0] : s[MAG_W-1:0];
  endfunction

  // Clamp the most negative code to its symmetric partner.
  function automatic logic [SPEED_W-1:0] speed_sat(input logic [SPEED_W-1:0] s);
    return (s == SPEED_MOST_NEG) ? SPEED_SAT_NEG : s;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/dual_quadrature_distance_drive_core.sv
// Top level: input register, drive state and result register of the drive block.
`timescale 1ns / 1ps
`default_nettype none

// Takes one beat per clock while the result side keeps up: an encoder sample
// (command 0) or a drive command (command 1), and returns one result beat for
// each. The beat lands in the input register, then the step logic updates the
// drive state and the result register as the beat advances. A stalled result
// holds the pipeline, limited by the single result register. min_speed is
// written through cfg_we/cfg_wdata and resets to 10; the user must write it
// only while the block is idle, which the block itself does not enforce.
module dual_quadrature_distance_drive_core import dqdd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [MAG_W-1:0]   cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               command,
  input  logic               left_chan_a,
  input  logic               left_chan_b,
  input  logic               right_chan_a,
  input  logic               right_chan_b,
  input  logic [SPEED_W-1:0] left_speed_cmd,
  input  logic [SPEED_W-1:0] right_speed_cmd,
  input  logic [DIST_W-1:0]  left_distance_cmd,
  input  logic [DIST_W-1:0]  right_distance_cmd,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               drive_enable,
  output logic               left_dir,
  output logic               right_dir,
  output logic [DIST_W-1:0]  left_compare,
  output logic [DIST_W-1:0]  right_compare,
  output logic [DIST_W-1:0]  left_remaining,
  output logic [DIST_W-1:0]  right_remaining,
  output logic               stopped_now
);

  logic [MAG_W-1:0] min_speed;
  logic             item_valid;
  item_t            item;
  drive_state_t     state, state_next;
  result_t          res, res_next;
  logic             advance;

  assign advance  = item_valid && (!out_valid || out_ready);
  assign in_ready = !item_valid || advance;

  // config register
  always_ff @(posedge clk) begin
    if (rst) min_speed <= 15'd10;
    else if (cfg_we) min_speed <= cfg_wdata;
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) item_valid <= 1'b0;
    else if (in_ready) item_valid <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= '{command: command, left_chan_a: left_chan_a, left_chan_b: left_chan_b,
                right_chan_a: right_chan_a, right_chan_b: right_chan_b,
                left_speed_cmd: left_speed_cmd, right_speed_cmd: right_speed_cmd,
                left_distance_cmd: left_distance_cmd,
                right_distance_cmd: right_distance_cmd};
    end
  end

  dqdd_step u_step (
    .item       (item),
    .state      (state),
    .min_speed  (min_speed),
    .state_next (state_next),
    .result     (res_next)
  );

  // drive state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{left_hist: '0, right_hist: '0, left_dist: NOT_SET_CODE,
                 right_dist: NOT_SET_CODE, left_speed: '0, right_speed: '0,
                 enabled: 1'b0};
    end else if (advance) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (advance) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (advance) res <= res_next;
  end

  assign drive_enable    = res.drive_enable;
  assign left_dir        = res.left_dir;
  assign right_dir       = res.right_dir;
  assign left_compare    = res.left_compare;
  assign right_compare   = res.right_compare;
  assign left_remaining  = res.left_remaining;
  assign right_remaining = res.right_remaining;
  assign stopped_now     = res.stopped_now;

  // a stop beat reports the halted drive
  a_stop_halts: assert property (@(posedge clk) disable iff (rst)
    out_valid && stopped_now |-> !drive_enable && left_compare == '0 &&
      right_compare == '0 && left_remaining == NOT_SET_CODE)
    else $error("stop beat does not show a halted drive");

  // enabled drive always has at least one distance set
  a_enabled_dist: assert property (@(posedge clk) disable iff (rst)
    state.enabled |-> !(state.left_dist == NOT_SET_CODE &&
      state.right_dist == NOT_SET_CODE))
    else $error("drive enabled with both distances not set");

  // state moves only when a beat is processed
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(state))
    else $error("drive state changed without a beat");

  // input stalls only behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> item_valid && out_valid && !out_ready)
    else $error("input stalled without a held result");

endmodule

`default_nettype wire

### hw/rtl/dqdd_step.sv
// Next-state and result logic for one beat: encoder tracking or drive load.
`timescale 1ns / 1ps
`default_nettype none

module dqdd_step import dqdd_pkg::*; (
  input  item_t              item,
  input  drive_state_t       state,
  input  logic [MAG_W-1:0]   min_speed,
  output drive_state_t       state_next,
  output result_t            result
);

  // left and right encoder
  logic [1:0]        pair_l, pair_r;
  logic              chg_l, chg_r;
  logic [HIST_W-1:0] hist_l, hist_r;
  logic [DIST_W-1:0] dec_l, dec_r, dist_r_eff;
  logic              cnt_l, cnt_r, stop_l, stop_r;
  // drive command
  logic [SPEED_W-1:0] ls, rs;
  logic               drive_stop;
  logic               halt;

  always_comb begin
    pair_l = {item.left_chan_a, item.left_chan_b};
    chg_l  = (state.left_hist[1:0] & PAIR_MASK) != pair_l;
    hist_l = {state.left_hist[1:0], pair_l} & HIST_MASK;
    dec_l  = state.left_dist - 16'd1;
    cnt_l  = chg_l && (state.left_dist != NOT_SET_CODE) && (state.left_dist != '0)
             && (STEP_TABLE[hist_l] != 2'sd0);
    stop_l = cnt_l && (dec_l == '0);
  end

  // right encoder sees the left stop within the same beat
  always_comb begin
    pair_r     = {item.right_chan_a, item.right_chan_b};
    chg_r      = (state.right_hist[1:0] & PAIR_MASK) != pair_r;
    hist_r     = {state.right_hist[1:0], pair_r} & HIST_MASK;
    dist_r_eff = stop_l ? NOT_SET_CODE : state.right_dist;
    dec_r      = dist_r_eff - 16'd1;
    cnt_r      = chg_r && (dist_r_eff != NOT_SET_CODE) && (dist_r_eff != '0)
                 && (STEP_TABLE[hist_r] != 2'sd0);
    stop_r     = cnt_r && (dec_r == '0);
  end

  // drive command checks
  always_comb begin
    ls = speed_sat(item.left_speed_cmd);
    rs = speed_sat(item.right_speed_cmd);
    drive_stop = ((speed_mag(ls) < min_speed) && (speed_mag(rs) < min_speed)) ||
                 ((item.left_distance_cmd == NOT_SET_CODE) &&
                  (item.right_distance_cmd == NOT_SET_CODE));
  end

  // state update
  always_comb begin
    state_next = state;
    if (item.command == CMD_SAMPLE) begin
      halt = stop_l || stop_r;
      if (chg_l) state_next.left_hist  = hist_l;
      if (chg_r) state_next.right_hist = hist_r;
      if (cnt_l) state_next.left_dist  = dec_l;
      if (cnt_r) state_next.right_dist = dec_r;
    end else begin
      halt = drive_stop;
      state_next.left_speed  = ls;
      state_next.right_speed = rs;
      state_next.left_dist   = item.left_distance_cmd;
      state_next.right_dist  = item.right_distance_cmd;
      state_next.enabled     = 1'b1;
    end
    if (halt) begin
      state_next.enabled     = 1'b0;
      state_next.left_speed  = '0;
      state_next.right_speed = '0;
      state_next.left_dist   = NOT_SET_CODE;
      state_next.right_dist  = NOT_SET_CODE;
    end
  end

  // outputs follow the state after the beat
  always_comb begin
    result.drive_enable    = state_next.enabled;
    result.left_dir        = !state_next.left_speed[SPEED_W-1] &&
                             (state_next.left_speed != '0);
    result.right_dir       = !(!state_next.right_speed[SPEED_W-1] &&
                               (state_next.right_speed != '0));
    result.left_compare    = {speed_mag(state_next.left_speed), 1'b0};
    result.right_compare   = {speed_mag(state_next.right_speed), 1'b0};
    result.left_remaining  = state_next.left_dist;
    result.right_remaining = state_next.right_dist;
    result.stopped_now     = halt;
  end

endmodule

`default_nettype wire

### dv/tb_top.sv
// Self-checking testbench for the dual quadrature distance drive core.
`timescale 1ns / 1ps

module tb_top;
  import dqdd_pkg::*;

  // Nonzero entries of the quadrature transition table, one bit per {old, new} pair
  localparam logic [15:0] VALID_STEPS = 16'h6996;
  localparam int unsigned ITEMS_PER_PHASE = 260;
  localparam int unsigned HOLD_CYCLES     = 250;

  // Drive state tracker: predicts the result beat of every accepted item
  class drive_tracker;
    logic [MAG_W-1:0]          min_speed;
    logic [HIST_W-1:0]         hist [2];
    logic [DIST_W-1:0]         remaining [2];
    logic signed [SPEED_W-1:0] speed [2];
    logic                      enabled;
    result_t                   pending_outputs [$];
    int unsigned               mismatches;
    int unsigned               outputs_checked;

    function new();
      min_speed = 15'd10;
      hist[0] = '0;
      hist[1] = '0;
      mismatches = 0;
      outputs_checked = 0;
      halt();
    endfunction

    function void halt();
      enabled      = 1'b0;
      speed[0]     = '0;
      speed[1]     = '0;
      remaining[0] = NOT_SET_CODE;
      remaining[1] = NOT_SET_CODE;
    endfunction

    function logic [SPEED_W-1:0] abs_speed(input logic signed [SPEED_W-1:0] s);
      return (s < 0) ? -s : s;
    endfunction

    function logic signed [SPEED_W-1:0] clamp_speed(input logic [SPEED_W-1:0] raw);
      return (raw == SPEED_MOST_NEG) ? SPEED_SAT_NEG : raw;
    endfunction

    // One encoder: returns 1 when its distance runs out on this step
    function bit step_motor(input int m, input logic [1:0] pair);
      logic [HIST_W-1:0] h;
      if (hist[m][1:0] == pair) return 1'b0;
      h = {hist[m][1:0], pair};
      hist[m] = h;
      if (remaining[m] != NOT_SET_CODE && remaining[m] != '0 && VALID_STEPS[h]) begin
        remaining[m] = remaining[m] - 1'b1;
        if (remaining[m] == '0) begin
          halt();
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    // Accepted input beat: update state and queue the expected result
    function void take_item(input item_t it);
      bit                        stop;
      logic signed [SPEED_W-1:0] ls, rs;
      result_t                   r;
      stop = 1'b0;
      if (it.command == CMD_SAMPLE) begin
        if (step_motor(0, {it.left_chan_a, it.left_chan_b})) stop = 1'b1;
        if (step_motor(1, {it.right_chan_a, it.right_chan_b})) stop = 1'b1;
      end else begin
        ls = clamp_speed(it.left_speed_cmd);
        rs = clamp_speed(it.right_speed_cmd);
        enabled = 1'b0;
        if ((abs_speed(ls) < min_speed && abs_speed(rs) < min_speed) ||
            (it.left_distance_cmd == NOT_SET_CODE && it.right_distance_cmd == NOT_SET_CODE)) begin
          halt();
          stop = 1'b1;
        end else begin
          speed[0]     = ls;
          speed[1]     = rs;
          remaining[0] = it.left_distance_cmd;
          remaining[1] = it.right_distance_cmd;
          enabled      = 1'b1;
        end
      end
      r.drive_enable    = enabled;
      r.left_dir        = (speed[0] > 0);
      r.right_dir       = !(speed[1] > 0);
      r.left_compare    = abs_speed(speed[0]) << 1;
      r.right_compare   = abs_speed(speed[1]) << 1;
      r.left_remaining  = remaining[0];
      r.right_remaining = remaining[1];
      r.stopped_now     = stop;
      pending_outputs.push_back(r);
    endfunction

    function void cmp(input string name, input int unsigned e, input int unsigned g);
      if (e != g) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, e, g);
        mismatches++;
      end
    endfunction

    // Accepted result beat: compare with the oldest expectation
    function void check_outputs(input result_t got);
      result_t e;
      outputs_checked++;
      if (pending_outputs.size() == 0) begin
        $display("%0t: result beat with none expected, expected none, actual %p", $time, got);
        mismatches++;
        return;
      end
      e = pending_outputs.pop_front();
      cmp("drive_enable", e.drive_enable, got.drive_enable);
      cmp("left_dir", e.left_dir, got.left_dir);
      cmp("right_dir", e.right_dir, got.right_dir);
      cmp("left_compare", e.left_compare, got.left_compare);
      cmp("right_compare", e.right_compare, got.right_compare);
      cmp("left_remaining", e.left_remaining, got.left_remaining);
      cmp("right_remaining", e.right_remaining, got.right_remaining);
      cmp("stopped_now", e.stopped_now, got.stopped_now);
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [MAG_W-1:0]   cfg_wdata;
  logic               in_valid;
  logic               in_ready;
  logic               command;
  logic               left_chan_a, left_chan_b, right_chan_a, right_chan_b;
  logic [SPEED_W-1:0] left_speed_cmd, right_speed_cmd;
  logic [DIST_W-1:0]  left_distance_cmd, right_distance_cmd;
  logic               out_valid;
  logic               out_ready;
  logic               drive_enable, left_dir, right_dir, stopped_now;
  logic [DIST_W-1:0]  left_compare, right_compare, left_remaining, right_remaining;

  drive_tracker tracker = new();
  bit           steady;       // no idling on either side while set
  logic [1:0]   left_pair;    // last encoder levels sent
  logic [1:0]   right_pair;

  dual_quadrature_distance_drive_core dut (
    .clk                (clk),
    .rst                (rst),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .command            (command),
    .left_chan_a        (left_chan_a),
    .left_chan_b        (left_chan_b),
    .right_chan_a       (right_chan_a),
    .right_chan_b       (right_chan_b),
    .left_speed_cmd     (left_speed_cmd),
    .right_speed_cmd    (right_speed_cmd),
    .left_distance_cmd  (left_distance_cmd),
    .right_distance_cmd (right_distance_cmd),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .drive_enable       (drive_enable),
    .left_dir           (left_dir),
    .right_dir          (right_dir),
    .left_compare       (left_compare),
    .right_compare      (right_compare),
    .left_remaining     (left_remaining),
    .right_remaining    (right_remaining),
    .stopped_now        (stopped_now)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Run limit
  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic item_t mk_sample(input logic la, lb, ra, rb);
    item_t it;
    it = '0;
    it.command      = CMD_SAMPLE;
    it.left_chan_a  = la;
    it.left_chan_b  = lb;
    it.right_chan_a = ra;
    it.right_chan_b = rb;
    return it;
  endfunction

  function automatic item_t mk_drive(input logic [15:0] ls, rs, ld, rd);
    item_t it;
    it = '0;
    it.command            = CMD_DRIVE;
    it.left_speed_cmd     = ls;
    it.right_speed_cmd    = rs;
    it.left_distance_cmd  = ld;
    it.right_distance_cmd = rd;
    return it;
  endfunction

  // Gray-code neighbor: 00 -> 01 -> 11 -> 10 -> 00 forward
  function automatic logic [1:0] gray_step(input logic [1:0] p, input bit fwd);
    case (p)
      2'b00: return fwd ? 2'b01 : 2'b10;
      2'b01: return fwd ? 2'b11 : 2'b00;
      2'b11: return fwd ? 2'b10 : 2'b01;
      default: return fwd ? 2'b00 : 2'b11;
    endcase
  endfunction

  function automatic logic [1:0] pick_pair(input logic [1:0] p);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return gray_step(p, 1'($urandom_range(1)));
    if (r < 85) return p;
    return 2'($urandom_range(3));
  endfunction

  function automatic logic [15:0] pick_speed();
    int m;
    case ($urandom_range(9))
      0, 1, 2: return 16'($urandom_range(65535));
      3, 4, 5: begin
        m = int'(tracker.min_speed) - 3 + int'($urandom_range(6));
        if (m < 0) m = 0;
        if (m > 32767) m = 32767;
        return $urandom_range(1) ? 16'(-m) : 16'(m);
      end
      6, 7: begin
        m = int'($urandom_range(40));
        return $urandom_range(1) ? 16'(-m) : 16'(m);
      end
      default: begin
        case ($urandom_range(3))
          0: return SPEED_MOST_NEG;
          1: return 16'h7FFF;
          2: return SPEED_SAT_NEG;
          default: return 16'h0000;
        endcase
      end
    endcase
  endfunction

  function automatic logic [15:0] pick_dist();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 40) return 16'($urandom_range(12, 1));
    if (r < 60) return NOT_SET_CODE;
    if (r < 70) return 16'h0000;
    if (r < 80) return 16'hFFFE;
    return 16'($urandom_range(65535));
  endfunction

  // Mostly well-formed encoder traffic, with drive commands mixed in
  function automatic item_t rand_item();
    item_t it;
    it = item_t'({$urandom(), $urandom(), $urandom()});
    if ($urandom_range(99) < 18) begin
      it.command            = CMD_DRIVE;
      it.left_speed_cmd     = pick_speed();
      it.right_speed_cmd    = pick_speed();
      it.left_distance_cmd  = pick_dist();
      it.right_distance_cmd = pick_dist();
    end else begin
      it.command = CMD_SAMPLE;
      {it.left_chan_a, it.left_chan_b}   = pick_pair(left_pair);
      {it.right_chan_a, it.right_chan_b} = pick_pair(right_pair);
    end
    return it;
  endfunction

  // Offer one input beat and hold it until accepted
  task automatic send_item(input item_t it);
    if (!steady && $urandom_range(99) < 34) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 34);
    end
    in_valid <= 1'b1;
    {command, left_chan_a, left_chan_b, right_chan_a, right_chan_b, left_speed_cmd,
     right_speed_cmd, left_distance_cmd, right_distance_cmd} <= it;
    do @(posedge clk); while (!in_ready);
    tracker.take_item(it);
    if (it.command == CMD_SAMPLE) begin
      left_pair  = {it.left_chan_a, it.left_chan_b};
      right_pair = {it.right_chan_a, it.right_chan_b};
    end
  endtask

  // Let every outstanding result drain, then let the pipeline settle
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (tracker.pending_outputs.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_min_speed(input logic [MAG_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.min_speed = v;
  endtask

  // Result side: random stalls, one long hold-off, check every beat
  initial begin
    bit          hold_done;
    int unsigned hold_left;
    hold_done = 1'b0;
    hold_left = 0;
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready)
        tracker.check_outputs({drive_enable, left_dir, right_dir, left_compare, right_compare,
                               left_remaining, right_remaining, stopped_now});
      if (!hold_done && tracker.outputs_checked >= 300) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= steady || ($urandom_range(99) >= 34);
      end
    end
  end

  // Stimulus
  initial begin
    int unsigned min_settings [5];
    min_settings = '{15'd0, 15'd32767, 15'd1, 15'($urandom_range(32767)), 15'd10};
    steady     = 1'b0;
    left_pair  = 2'b00;
    right_pair = 2'b00;
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    in_valid  <= 1'b0;
    {command, left_chan_a, left_chan_b, right_chan_a, right_chan_b, left_speed_cmd,
     right_speed_cmd, left_distance_cmd, right_distance_cmd} <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: stop conditions, saturation, step counting, zero distance
    send_item(mk_sample(0, 0, 0, 0));                          // no phase change
    send_item(mk_drive(16'd5, -16'sd9, 16'd10, 16'd10));       // both speeds below minimum
    send_item(mk_drive(16'd100, 16'd200, NOT_SET_CODE, NOT_SET_CODE)); // both not set
    send_item(mk_drive(SPEED_MOST_NEG, 16'h7FFF, 16'd3, NOT_SET_CODE)); // saturated speed
    send_item(mk_sample(0, 1, 0, 0));
    send_item(mk_sample(1, 1, 0, 0));
    send_item(mk_sample(0, 0, 0, 0));                          // illegal jump, not counted
    send_item(mk_sample(1, 0, 0, 1));                          // left runs out, right still tracked
    send_item(mk_drive(16'd9, 16'd10, 16'd0, 16'd0));          // zero distances
    send_item(mk_sample(1, 1, 1, 1));                          // zero distance never counts
    send_item(mk_drive(-16'sd1, -16'sd10, 16'hFFFE, 16'd1));
    send_item(mk_sample(1, 1, 1, 0));                          // right runs out
    send_item(mk_drive(16'd300, -16'sd300, 16'd1, 16'd1));
    send_item(mk_sample(0, 1, 0, 0));                          // left runs out, right not counted
    send_item(mk_drive(16'd0, 16'd0, 16'd5, 16'd5));
    send_item(mk_drive(16'h7FFF, SPEED_SAT_NEG, 16'h8000, 16'h7FFF));
    send_item(mk_drive(SPEED_MOST_NEG, SPEED_MOST_NEG, NOT_SET_CODE, 16'd12));
    send_item(mk_sample(0, 1, 0, 0));                          // no change
    send_item(mk_sample(1, 0, 1, 1));
    send_item(mk_drive(16'hFFFF, 16'h0001, 16'h5555, 16'hAAAA));
    send_item(mk_sample(1, 1, 0, 1));
    drain();

    // Random phases, one minimum-speed setting each
    for (int p = 0; p < 5; p++) begin
      write_min_speed(min_settings[p][MAG_W-1:0]);
      steady = (p == 2);
      repeat (ITEMS_PER_PHASE) send_item(rand_item());
      drain();
    end
    steady = 1'b0;
    repeat (8) @(posedge clk);

    if (tracker.mismatches == 0 && tracker.pending_outputs.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/dqdd_pkg.sv
hw/rtl/dqdd_step.sv
hw/rtl/dual_quadrature_distance_drive_core.sv
dv/tb_top.sv
